### hdl/nesr_pkg.sv
// nesr_pkg: constants, types and codes shared by the nearest endpoint search blocks.
// No dependencies.
package nesr_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 3);
    localparam int COORD_W       = 32;
    localparam int DIST_W        = 33;
    localparam int SLOT_W        = 6;
    localparam int STATUS_W      = 3;
    localparam int CMD_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED    = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CLEARED   = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } seg_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
        logic kill;
        logic clear;
    } cell_ctrl_t;

    // running best of the search unit
    typedef struct packed {
        logic              have;
        logic [DIST_W-1:0] mdist;
        logic [IDX_W-1:0]  slot;
        seg_t              seg;
    } best_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        seg_t              seg;
        logic [DIST_W-1:0] mdist;
    } result_t;

endpackage

### hdl/nesr_cell.sv
// nesr_cell: one table slot, a segment and its live bit, in a rotating chain.
// Depends on nesr_pkg.
module nesr_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  nesr_pkg::cell_ctrl_t ctrl,
    input  nesr_pkg::seg_t      load_seg,
    input  nesr_pkg::seg_t      nbr_seg,
    input  logic                nbr_live,
    output nesr_pkg::seg_t      seg,
    output logic                live
);
    import nesr_pkg::*;

    seg_t seg_reg, seg_next;
    logic live_reg, live_next;

    always_comb
    begin
        seg_next  = seg_reg;
        live_next = live_reg;
        if (ctrl.clear)
        begin
            live_next = 1'b0;
        end
        else if (ctrl.load)
        begin
            seg_next  = load_seg;
            live_next = 1'b1;
        end
        else if (ctrl.kill)
        begin
            live_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            seg_next  = nbr_seg;
            live_next = nbr_live;
        end
    end

    // point store has no reset; only live slots are ever looked at
    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    assign seg  = seg_reg;
    assign live = live_reg;

endmodule

### hdl/nesr_eval.sv
// nesr_eval: three-stage Manhattan distance unit and running-best register.
// Depends on nesr_pkg.
module nesr_eval (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              feed_valid,
    input  logic [nesr_pkg::IDX_W-1:0]        feed_slot,
    input  nesr_pkg::seg_t                    feed_seg,
    input  logic signed [nesr_pkg::COORD_W-1:0] qx,
    input  logic signed [nesr_pkg::COORD_W-1:0] qy,
    output nesr_pkg::best_t                   best
);
    import nesr_pkg::*;

    // |a-b| of two signed words always fits the unsigned word
    function automatic logic [COORD_W-1:0] absdiff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
        logic [COORD_W-1:0] d_ab;
        logic [COORD_W-1:0] d_ba;
        d_ab = COORD_W'(a - b);
        d_ba = COORD_W'(b - a);
        return (a > b) ? d_ab : d_ba;
    endfunction

    // stage A: coordinate magnitudes
    logic               a_valid_reg;
    logic [IDX_W-1:0]   a_slot_reg;
    seg_t               a_seg_reg;
    logic [COORD_W-1:0] a_sx_reg, a_sy_reg, a_ex_reg, a_ey_reg;

    // stage B: smaller of the two endpoint distances
    logic               b_valid_reg;
    logic [IDX_W-1:0]   b_slot_reg;
    seg_t               b_seg_reg;
    logic [DIST_W-1:0]  b_dist_reg;

    logic [DIST_W-1:0]  d_start, d_end, d_min;
    best_t              best_reg, best_next;

    assign d_start = {1'b0, a_sx_reg} + {1'b0, a_sy_reg};
    assign d_end   = {1'b0, a_ex_reg} + {1'b0, a_ey_reg};
    // end point wins only when strictly nearer
    assign d_min   = (d_end < d_start) ? d_end : d_start;

    always_comb
    begin
        best_next = best_reg;
        if (start)
        begin
            best_next.have  = 1'b0;
            best_next.mdist = '0;
        end
        else if (b_valid_reg && (!best_reg.have || b_dist_reg < best_reg.mdist))
        begin
            best_next.have  = 1'b1;
            best_next.mdist = b_dist_reg;
            best_next.slot  = b_slot_reg;
            best_next.seg   = b_seg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_slot_reg <= feed_slot;
        a_seg_reg  <= feed_seg;
        a_sx_reg   <= absdiff(qx, feed_seg.sx);
        a_sy_reg   <= absdiff(qy, feed_seg.sy);
        a_ex_reg   <= absdiff(qx, feed_seg.ex);
        a_ey_reg   <= absdiff(qy, feed_seg.ey);
        b_slot_reg <= a_slot_reg;
        b_seg_reg  <= a_seg_reg;
        b_dist_reg <= d_min;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            best_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= feed_valid;
            b_valid_reg <= a_valid_reg;
            best_reg    <= best_next;
        end
    end

    assign best = best_reg;

endmodule

### hdl/nearest_endpoint_search_remove.sv
// nearest_endpoint_search_remove: segment table with nearest-endpoint query and removal.
// Depends on nesr_pkg, nesr_cell (one per slot) and nesr_eval.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  input    | in_valid/in_ready  | cmd, seg_start_*, seg_end_*, query_x, query_y
//  output   | out_valid/out_ready| status, slot, found_start_*, found_end_*, distance
//  config   | cfg_we             | cfg_wdata -> tolerance
//
// Load, clear and unused commands: accepted in IDLE, the result is registered and
// moves to the output register in FLUSH once that is free. Query: after acceptance
// the slot chain rotates once past the head cell, one slot a cycle, then the
// three-stage distance unit drains, the decision cycle removes the winner if it is
// within tolerance, and the result passes through FLUSH in the same way.
// One transaction is worked on at a time; the next is taken as soon as the result
// has moved to the output register, even if it is still waiting there.
// Reset clears live bits, fill count and tolerance at once; no clearing pass.
module nearest_endpoint_search_remove (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [nesr_pkg::CMD_W-1:0]           cmd,
    input  logic signed [nesr_pkg::COORD_W-1:0]  seg_start_x,
    input  logic signed [nesr_pkg::COORD_W-1:0]  seg_start_y,
    input  logic signed [nesr_pkg::COORD_W-1:0]  seg_end_x,
    input  logic signed [nesr_pkg::COORD_W-1:0]  seg_end_y,
    input  logic signed [nesr_pkg::COORD_W-1:0]  query_x,
    input  logic signed [nesr_pkg::COORD_W-1:0]  query_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [nesr_pkg::STATUS_W-1:0]        status,
    output logic [nesr_pkg::SLOT_W-1:0]          slot,
    output logic signed [nesr_pkg::COORD_W-1:0]  found_start_x,
    output logic signed [nesr_pkg::COORD_W-1:0]  found_start_y,
    output logic signed [nesr_pkg::COORD_W-1:0]  found_end_x,
    output logic signed [nesr_pkg::COORD_W-1:0]  found_end_y,
    output logic [nesr_pkg::DIST_W-1:0]          distance,
    input  logic                                 cfg_we,
    input  logic [nesr_pkg::COORD_W-1:0]         cfg_wdata
);
    import nesr_pkg::*;

    localparam logic [CNT_W-1:0]  SCAN_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0]  SCAN_LAST = CNT_W'(TABLE_ENTRIES + 2);
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [COORD_W-1:0]         tol_reg, tol_next;
    logic signed [COORD_W-1:0]  qx_reg, qx_next, qy_reg, qy_next;
    result_t                    res_reg, res_next;
    result_t                    out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    logic        accept;
    logic        load_go, kill_go, clear_go, shift_go, start_go, feed_go;
    seg_t        in_seg;
    best_t       best;
    logic        in_tol;

    seg_t                   cell_seg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] live_vec;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign in_seg   = '{sx: seg_start_x, sy: seg_start_y, ex: seg_end_x, ey: seg_end_y};
    assign in_tol   = best.have && (best.mdist <= {1'b0, tol_reg});
    assign feed_go  = (state_reg == S_SCAN) && (cnt_reg < SCAN_END);
    assign shift_go = feed_go;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        tol_next       = cfg_we ? cfg_wdata : tol_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_go        = 1'b0;
        kill_go        = 1'b0;
        clear_go       = 1'b0;
        start_go       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    state_next = S_FLUSH;
                    case (cmd)
                        CMD_LOAD:
                        begin
                            if (fill_reg >= FILL_MAX)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                load_go         = 1'b1;
                                fill_next       = fill_reg + 1'b1;
                                res_next.status = ST_LOADED;
                                res_next.slot   = SLOT_W'(fill_reg);
                            end
                        end
                        CMD_QUERY:
                        begin
                            start_go   = 1'b1;
                            qx_next    = query_x;
                            qy_next    = query_y;
                            cnt_next   = '0;
                            state_next = S_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            clear_go        = 1'b1;
                            fill_next       = '0;
                            res_next.status = ST_CLEARED;
                        end
                        default:
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_LAST)
                begin
                    res_next        = '0;
                    res_next.status = ST_NOT_FOUND;
                    res_next.mdist  = best.have ? best.mdist : '0;
                    if (in_tol)
                    begin
                        kill_go         = 1'b1;
                        res_next.status = ST_FOUND;
                        res_next.slot   = SLOT_W'(best.slot);
                        res_next.seg    = best.seg;
                    end
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        qx_reg  <= qx_next;
        qy_reg  <= qy_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            tol_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            tol_reg       <= tol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // slot chain: cell i takes from cell i+1 and the last wraps to the first, so
    // after TABLE_ENTRIES shifts every slot is back in place
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % TABLE_ENTRIES;
        cell_ctrl_t ctrl;

        assign ctrl.shift = shift_go;
        assign ctrl.load  = load_go && (fill_reg == FILL_W'(i));
        assign ctrl.kill  = kill_go && (best.slot == IDX_W'(i));
        assign ctrl.clear = clear_go;

        nesr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .load_seg (in_seg),
            .nbr_seg  (cell_seg[NXT]),
            .nbr_live (live_vec[NXT]),
            .seg      (cell_seg[i]),
            .live     (live_vec[i])
        );
    end

    // head cell feeds the distance unit; dead slots are not offered
    nesr_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start_go),
        .feed_valid (feed_go && live_vec[0]),
        .feed_slot  (cnt_reg[IDX_W-1:0]),
        .feed_seg   (cell_seg[0]),
        .qx         (qx_reg),
        .qy         (qy_reg),
        .best       (best)
    );

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign slot          = out_reg.slot;
    assign found_start_x = out_reg.seg.sx;
    assign found_start_y = out_reg.seg.sy;
    assign found_end_x   = out_reg.seg.ex;
    assign found_end_y   = out_reg.seg.ey;
    assign distance      = out_reg.mdist;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count beyond table size");

    a_live_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN) |-> ((live_vec >> fill_reg) == '0))
        else $error("live slot at or above fill count");

    a_found_in_tol: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_FOUND) |-> (out_reg.mdist <= {1'b0, tol_reg}))
        else $error("removed segment outside tolerance");

    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cnt_reg == SCAN_LAST && in_tol)
        |=> !live_vec[$past(best.slot)])
        else $error("found slot still live");
`endif

endmodule
